[rtl/akds_pkg.sv]
// akds_pkg: register indexes, mask constants and keystream generator functions
// for the address keyed data scrambler; no dependencies
package akds_pkg;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_KEY_A   = 2'd0,
        REG_KEY_B   = 2'd1,
        REG_RANDOM  = 2'd2,
        REG_CONTROL = 2'd3
    } t_reg_idx;

    localparam logic [15:0] GEN16_MASK = 16'h6371;
    localparam logic [16:0] GEN17_MASK = 17'h13659;
    localparam logic [31:0] GEN32_MASK = 32'hE519A4F1;

    // control word fields
    localparam int CTL_BYP16   = 0;
    localparam int CTL_BYP17   = 1;
    localparam int CTL_BYP32   = 2;
    localparam int CTL_BYPRND  = 3;
    localparam int CTL_KEYBIT  = 4;

    // 16-bit generator: rotate left by 9, mix with replicated nibble
    function automatic logic [15:0] gen16(input logic [15:0] x);
        logic [15:0] rot;
        logic [3:0]  nib;
        rot = {x[6:0], x[15:7]};
        nib = x[8:5];
        return rot ^ (GEN16_MASK & {4{nib}});
    endfunction

    // 17-bit generator: rotate left by 7, mix with scattered address bits
    function automatic logic [16:0] gen17(input logic [16:0] x);
        logic [16:0] rot;
        logic [3:0]  nib;
        rot = {x[9:0], x[16:10]};
        nib = {x[1], x[5], x[9], x[13]};
        return rot ^ (GEN17_MASK & {x[4], {4{nib}}});
    endfunction

    // 32-bit generator: rotate left by 17, mix with replicated nibble
    function automatic logic [31:0] gen32(input logic [31:0] x);
        logic [31:0] rot;
        logic [3:0]  nib;
        rot = {x[14:0], x[31:15]};
        nib = x[5:2];
        return rot ^ (GEN32_MASK & {8{nib}});
    endfunction

    // byte swap of a half word
    function automatic logic [15:0] swap16(input logic [15:0] h);
        return {h[7:0], h[15:8]};
    endfunction

endpackage

[rtl/address_keyed_data_scrambler.sv]
// address_keyed_data_scrambler: top level, three stage scrambling pipeline
// depends on akds_pkg
//
// A word started at a rising edge comes back with o_done high after it has passed the
// stage 1, 2 and 3 registers, and a new word may be started in every cycle: o_busy is
// always low. The depth is set by the three register stages: address forming and keying,
// the three generators, and the final keystream combine with the data. Each result
// sits on o_data_out for the one cycle that o_done is high; the receiver cannot
// stall it. Encryption and decryption are the same operation. Configuration is
// sampled when a word enters; bits 31:24 of the control word all zeros or all ones
// pass data through unchanged.
module address_keyed_data_scrambler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [31:0] i_bus_address,
    input  logic [31:0] i_data_in,
    output logic        o_done,
    output logic [31:0] o_data_out,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    import akds_pkg::*;

    logic [31:0] r_key_a, r_key_b, r_random, r_control;

    logic        r_v1, r_v2, r_v3;
    logic [15:0] r1_a16;
    logic [16:0] r1_a17;
    logic [31:0] r1_a32, r1_rnd, r1_data;
    logic [2:0]  r1_kill;
    logic [15:0] r2_p16, r2_p17;
    logic [31:0] r2_p32, r2_rnd, r2_data;
    logic [31:0] r3_data_out;

    logic [15:0] n_a16, hi_form, lo_form;
    logic [16:0] n_a17, k17;
    logic [31:0] n_a32, a32_rot, a17_shift, n_rnd;
    logic [2:0]  n_kill;
    logic        all_off;
    logic [16:0] p17_full;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_a   <= '0;
            r_key_b   <= '0;
            r_random  <= '0;
            r_control <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_KEY_A:   r_key_a   <= i_cfg_data;
                REG_KEY_B:   r_key_b   <= i_cfg_data;
                REG_RANDOM:  r_random  <= i_cfg_data;
                REG_CONTROL: r_control <= i_cfg_data;
                default:     r_key_a   <= r_key_a;
            endcase
        end
    end

    // stage 1: address forms, key mixing and bypass decode
    always_comb begin
        all_off = (r_control[31:24] == 8'h00) || (r_control[31:24] == 8'hFF);

        hi_form = r_control[6] ? swap16(i_bus_address[31:16]) : i_bus_address[31:16];
        lo_form = r_control[5] ? swap16(i_bus_address[15:0]) : i_bus_address[15:0];
        n_a16   = hi_form ^ lo_form ^ r_key_b[31:16];

        k17       = {r_key_b[15:8], r_control[CTL_KEYBIT], r_key_b[7:0]};
        a17_shift = i_bus_address >> r_control[9:8];
        n_a17     = a17_shift[16:0] ^ k17;

        case (r_control[12:11])
            2'd0:    a32_rot = i_bus_address;
            2'd1:    a32_rot = {i_bus_address[7:0], i_bus_address[31:8]};
            2'd2:    a32_rot = {i_bus_address[15:0], i_bus_address[31:16]};
            default: a32_rot = {i_bus_address[23:0], i_bus_address[31:24]};
        endcase
        n_a32 = a32_rot ^ r_key_a;

        n_kill = {all_off | r_control[CTL_BYP32],
                  all_off | r_control[CTL_BYP17],
                  all_off | r_control[CTL_BYP16]};
        n_rnd  = (all_off | r_control[CTL_BYPRND]) ? '0 : r_random;
    end

    always_ff @(posedge i_clk) begin
        r1_a16  <= n_a16;
        r1_a17  <= n_a17;
        r1_a32  <= n_a32;
        r1_kill <= n_kill;
        r1_rnd  <= n_rnd;
        r1_data <= i_data_in;
    end

    // stage 2: the three generators, gated by their bypasses
    assign p17_full = gen17(r1_a17);

    always_ff @(posedge i_clk) begin
        r2_p16  <= r1_kill[0] ? '0 : gen16(r1_a16);
        r2_p17  <= r1_kill[1] ? '0 : p17_full[15:0];
        r2_p32  <= r1_kill[2] ? '0 : gen32(r1_a32);
        r2_rnd  <= r1_rnd;
        r2_data <= r1_data;
    end

    // stage 3: combine keystream with the data word
    always_ff @(posedge i_clk) begin
        r3_data_out <= r2_data ^ r2_p32 ^ {r2_p16, r2_p17} ^ r2_rnd;
    end

    // valid bits travel with the word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    assign o_busy     = 1'b0;
    assign o_done     = r_v3;
    assign o_data_out = r3_data_out;

endmodule

[rtl/akds_checker.sv]
// akds_checker: port level assertions for address_keyed_data_scrambler, bound to it
// depends on akds_pkg
module akds_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_start,
    input logic        o_busy,
    input logic [31:0] i_data_in,
    input logic        o_done,
    input logic [31:0] o_data_out,
    input logic        i_cfg_we,
    input logic [1:0]  i_cfg_idx,
    input logic [31:0] i_cfg_data
);
    import akds_pkg::*;

    logic       r_pass;
    logic [2:0] r_rst_hist;
    logic       settled;

    // shadow of the global pass-through condition
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pass <= 1'b1;
        end else if (i_cfg_we && (i_cfg_idx == REG_CONTROL)) begin
            r_pass <= (i_cfg_data[31:24] == 8'h00) || (i_cfg_data[31:24] == 8'hFF);
        end
    end

    // history of reset release; settled once the history register has filled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rst_hist <= 3'b000;
        end else begin
            r_rst_hist <= {r_rst_hist[1:0], 1'b1};
        end
    end

    assign settled = i_rst_n && r_rst_hist[2];

    // a word can always be started
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !o_busy)
        else $error("scrambler reported busy");

    // a strobe follows each start through the pipeline and comes at no other time
    a_done_timing: assert property (@(posedge i_clk)
        settled |-> (o_done == $past(i_start, 3)))
        else $error("result strobe out of step with start");

    // global pass-through returns the data word unchanged
    a_pass_through: assert property (@(posedge i_clk)
        (settled && o_done && $past(r_pass, 3)) |-> (o_data_out == $past(i_data_in, 3)))
        else $error("pass-through word altered");

endmodule

bind address_keyed_data_scrambler akds_checker u_akds_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_start    (i_start),
    .o_busy     (o_busy),
    .i_data_in  (i_data_in),
    .o_done     (o_done),
    .o_data_out (o_data_out),
    .i_cfg_we   (i_cfg_we),
    .i_cfg_idx  (i_cfg_idx),
    .i_cfg_data (i_cfg_data)
);

[sim/address_keyed_data_scrambler_tb.sv]
// address_keyed_data_scrambler_tb: self-checking bench for the address keyed data scrambler,
// a directed table followed by randomized words and key settings checked by a keystream predictor
// depends on akds_pkg and address_keyed_data_scrambler
module address_keyed_data_scrambler_tb;
    import akds_pkg::*;

    localparam int LATENCY      = 3;
    localparam int STALL_LIMIT  = 2000;
    localparam int PHASE_WORDS  = 425;
    localparam int KEY_INTERVAL = 85;

    // keystream mixing masks
    localparam logic [15:0] HI_MIX  = 16'h6371;
    localparam logic [16:0] LO_MIX  = 17'h13659;
    localparam logic [31:0] FULL_MIX = 32'hE519A4F1;

    typedef enum logic {
        ROW_WORD,
        ROW_SETUP
    } t_row_kind;

    // word rows: f0 address, f1 data; setup rows: f0..f3 key a, key b, random, control
    typedef struct packed {
        t_row_kind   kind;
        logic        has_lit;
        logic [31:0] lit;
        logic [31:0] f0;
        logic [31:0] f1;
        logic [31:0] f2;
        logic [31:0] f3;
    } t_row;

    typedef struct {
        logic [31:0] addr;
        logic [31:0] din;
        logic [31:0] dout;
    } t_scrambled;

    localparam int NUM_ROWS = 29;
    localparam t_row DIRECTED_ROWS [NUM_ROWS] = '{
        // after reset the top control byte is zero: pass through
        '{ROW_WORD,  1'b1, 32'h00000000, 32'h00000000, 32'h00000000, 32'h0, 32'h0},
        '{ROW_WORD,  1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0, 32'h0},
        '{ROW_WORD,  1'b1, 32'hA5A5A5A5, 32'h12345678, 32'hA5A5A5A5, 32'h0, 32'h0},
        // top byte all ones: pass through despite keys
        '{ROW_SETUP, 1'b0, 32'h0, 32'hDEADBEEF, 32'hCAFEF00D, 32'h13579BDF, 32'hFF001FFF},
        '{ROW_WORD,  1'b1, 32'h0F0F0F0F, 32'h89ABCDEF, 32'h0F0F0F0F, 32'h0, 32'h0},
        // enabled, every part bypassed
        '{ROW_SETUP, 1'b0, 32'h0, 32'hDEADBEEF, 32'hCAFEF00D, 32'h13579BDF, 32'h0100000F},
        '{ROW_WORD,  1'b1, 32'h00000000, 32'hFFFFFFFF, 32'h00000000, 32'h0, 32'h0},
        // random word only
        '{ROW_SETUP, 1'b0, 32'h0, 32'hDEADBEEF, 32'hCAFEF00D, 32'h13579BDF, 32'h01000007},
        '{ROW_WORD,  1'b1, 32'h13579BDF, 32'h00000000, 32'h00000000, 32'h0, 32'h0},
        '{ROW_WORD,  1'b1, 32'hECA86420, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0, 32'h0},
        // all generators, zero keys, plain address forms
        '{ROW_SETUP, 1'b0, 32'h0, 32'h00000000, 32'h00000000, 32'h00000000, 32'h80000000},
        '{ROW_WORD,  1'b0, 32'h0, 32'h00000000, 32'h00000000, 32'h0, 32'h0},
        '{ROW_WORD,  1'b0, 32'h0, 32'hFFFFFFFF, 32'h00000000, 32'h0, 32'h0},
        // all ones keys, key bit set, selectors at three
        '{ROW_SETUP, 1'b0, 32'h0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h7F001B70},
        '{ROW_WORD,  1'b0, 32'h0, 32'h00000000, 32'hFFFFFFFF, 32'h0, 32'h0},
        '{ROW_WORD,  1'b0, 32'h0, 32'hFFFFFFFF, 32'h00000000, 32'h0, 32'h0},
        '{ROW_WORD,  1'b0, 32'h0, 32'h80000001, 32'h7FFFFFFE, 32'h0, 32'h0},
        // selectors at one, unused control bits all set
        '{ROW_SETUP, 1'b0, 32'h0, 32'hA5A5A5A5, 32'h5A5A5A5A, 32'h00000000, 32'h01FFEDA0},
        '{ROW_WORD,  1'b0, 32'h0, 32'h0000FFFF, 32'h12345678, 32'h0, 32'h0},
        '{ROW_WORD,  1'b0, 32'h0, 32'hFFFF0000, 32'h87654321, 32'h0, 32'h0},
        // selectors at two
        '{ROW_SETUP, 1'b0, 32'h0, 32'h00000000, 32'h00FF00FF, 32'h00000000, 32'hFE001250},
        '{ROW_WORD,  1'b0, 32'h0, 32'h01234567, 32'hDEADBEEF, 32'h0, 32'h0},
        '{ROW_WORD,  1'b0, 32'h0, 32'hFEDCBA98, 32'h00000000, 32'h0, 32'h0},
        // one generator at a time: upper half, lower half, full word
        '{ROW_SETUP, 1'b0, 32'h0, 32'h00000000, 32'h12345678, 32'h00000000, 32'h0200000E},
        '{ROW_WORD,  1'b0, 32'h0, 32'h13579BDF, 32'h00000000, 32'h0, 32'h0},
        '{ROW_SETUP, 1'b0, 32'h0, 32'h00000000, 32'h12345678, 32'h00000000, 32'h0300001D},
        '{ROW_WORD,  1'b0, 32'h0, 32'h13579BDF, 32'h00000000, 32'h0, 32'h0},
        '{ROW_SETUP, 1'b0, 32'h0, 32'h9ABCDEF0, 32'h12345678, 32'h00000000, 32'h0400180B},
        '{ROW_WORD,  1'b0, 32'h0, 32'h13579BDF, 32'h00000000, 32'h0, 32'h0}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic [31:0] i_bus_address;
    logic [31:0] i_data_in;
    logic        o_done;
    logic [31:0] o_data_out;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    // shadow of the key and control registers
    logic [31:0] key_a;
    logic [31:0] key_b;
    logic [31:0] rand_w;
    logic [31:0] ctl_w;

    t_scrambled  expected_words [$];
    int          err_count;
    int          quiet_cycles;
    logic        lit_pending;
    logic [31:0] lit_value;

    address_keyed_data_scrambler uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_bus_address (i_bus_address),
        .i_data_in     (i_data_in),
        .o_done        (o_done),
        .o_data_out    (o_data_out),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // upper half generator: rotate left 9, mask by repeated address nibble
    function automatic logic [15:0] hi_stream(input logic [15:0] x);
        logic [15:0] spun;
        spun = (x << 9) | (x >> 7);
        return spun ^ (HI_MIX & {4{x[8:5]}});
    endfunction

    // lower half generator: rotate left 7 over 17 bits, scattered address nibble
    function automatic logic [16:0] lo_stream(input logic [16:0] x);
        logic [16:0] spun;
        logic [3:0]  nib;
        spun = (x << 7) | (x >> 10);
        nib  = {x[1], x[5], x[9], x[13]};
        return spun ^ (LO_MIX & {x[4], {4{nib}}});
    endfunction

    // full word generator: rotate left 17, mask by repeated address nibble
    function automatic logic [31:0] full_stream(input logic [31:0] x);
        logic [31:0] spun;
        spun = (x << 17) | (x >> 15);
        return spun ^ (FULL_MIX & {8{x[5:2]}});
    endfunction

    // data word XOR the keystream built from the address and the shadow registers
    function automatic logic [31:0] scrambled_word(input logic [31:0] addr,
                                                   input logic [31:0] din);
        logic [15:0] hi;
        logic [15:0] lo;
        logic [15:0] p16;
        logic [16:0] a17;
        logic [16:0] p17;
        logic [31:0] a32;
        logic [31:0] p32;
        logic [31:0] rnd;
        logic        off;
        off = (ctl_w[31:24] == 8'h00) || (ctl_w[31:24] == 8'hFF);
        hi  = addr[31:16];
        lo  = addr[15:0];
        if (ctl_w[6]) hi = {hi[7:0], hi[15:8]};
        if (ctl_w[5]) lo = {lo[7:0], lo[15:8]};
        a17 = 17'(addr >> ctl_w[9:8]) ^ {key_b[15:8], ctl_w[4], key_b[7:0]};
        a32 = 32'({addr, addr} >> (8 * ctl_w[12:11])) ^ key_a;
        p16 = (off || ctl_w[0]) ? 16'h0 : hi_stream(hi ^ lo ^ key_b[31:16]);
        p17 = (off || ctl_w[1]) ? 17'h0 : lo_stream(a17);
        p32 = (off || ctl_w[2]) ? 32'h0 : full_stream(a32);
        rnd = (off || ctl_w[3]) ? 32'h0 : rand_w;
        return din ^ p32 ^ {p16, p17[15:0]} ^ rnd;
    endfunction

    // random field value, now and then an extreme or a walking bit
    function automatic logic [31:0] pick_word();
        logic [31:0] bit_one;
        bit_one = 32'h1 << $urandom_range(31);
        case ($urandom_range(15))
            0:       return 32'h00000000;
            1:       return 32'hFFFFFFFF;
            2:       return bit_one;
            3:       return ~bit_one;
            default: return $urandom;
        endcase
    endfunction

    // monitor: everything sampled mid-cycle, i.e. what the next rising edge takes
    always @(negedge i_clk) begin : monitor
        t_scrambled head;
        t_scrambled entry;
        logic       moved;
        moved = 1'b0;
        if (i_rst_n && o_done) begin
            moved = 1'b1;
            if (expected_words.size() == 0) begin
                $error("data_out: no word outstanding, got %h", o_data_out);
                err_count++;
            end else begin
                head = expected_words.pop_front();
                if (o_data_out !== head.dout) begin
                    $error("data_out: expected %h, actual %h (address %h, data_in %h)",
                           head.dout, o_data_out, head.addr, head.din);
                    err_count++;
                end
            end
        end
        if (i_rst_n && i_start && !o_busy) begin
            moved      = 1'b1;
            entry.addr = i_bus_address;
            entry.din  = i_data_in;
            entry.dout = lit_pending ? lit_value : scrambled_word(i_bus_address, i_data_in);
            expected_words.push_back(entry);
        end
        if (i_rst_n && i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_KEY_A:   key_a  = i_cfg_data;
                REG_KEY_B:   key_b  = i_cfg_data;
                REG_RANDOM:  rand_w = i_cfg_data;
                REG_CONTROL: ctl_w  = i_cfg_data;
                default:     ;
            endcase
        end
        // watchdog on cycles with neither a word taken nor a result
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // present one word and hold it until it is taken; called and returns at a rising edge
    task automatic push_word(input logic [31:0] addr, input logic [31:0] data);
        logic took;
        i_start       <= 1'b1;
        i_bus_address <= addr;
        i_data_in     <= data;
        do begin
            @(negedge i_clk);
            took = !o_busy;
            @(posedge i_clk);
        end while (!took);
        lit_pending = 1'b0;
    endtask

    // sender idles each cycle with the given chance in percent
    task automatic sender_gap(input int pct);
        while ($urandom_range(99) < pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // stop sending and let every outstanding word come back
    task automatic drain();
        i_start <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 1) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    // load all four registers while the block is idle
    task automatic load_keys(input logic [31:0] ka, input logic [31:0] kb,
                             input logic [31:0] rw, input logic [31:0] cw);
        drain();
        write_reg(REG_KEY_A, ka);
        write_reg(REG_KEY_B, kb);
        write_reg(REG_RANDOM, rw);
        write_reg(REG_CONTROL, cw);
        i_cfg_we <= 1'b0;
    endtask

    // random key setting, mostly enabled with some parts bypassed
    task automatic random_keys();
        logic [31:0] cw;
        cw = $urandom;
        case ($urandom_range(9))
            0:       cw[31:24] = 8'h00;
            1:       cw[31:24] = 8'hFF;
            default: cw[31:24] = 8'($urandom_range(254, 1));
        endcase
        if ($urandom_range(1) == 0) cw[3:0] = 4'h0;
        load_keys(pick_word(), pick_word(), pick_word(), cw);
    endtask

    initial begin : stimulus
        int pct [4];
        pct = '{0, 57, 16, 0};
        err_count     = 0;
        quiet_cycles  = 0;
        lit_pending   = 1'b0;
        lit_value     = 32'h0;
        key_a         = 32'h0;
        key_b         = 32'h0;
        rand_w        = 32'h0;
        ctl_w         = 32'h0;
        i_rst_n       <= 1'b0;
        i_start       <= 1'b0;
        i_bus_address <= 32'h0;
        i_data_in     <= 32'h0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= REG_KEY_A;
        i_cfg_data    <= 32'h0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed table
        for (int r = 0; r < NUM_ROWS; r++) begin
            if (DIRECTED_ROWS[r].kind == ROW_SETUP) begin
                load_keys(DIRECTED_ROWS[r].f0, DIRECTED_ROWS[r].f1,
                          DIRECTED_ROWS[r].f2, DIRECTED_ROWS[r].f3);
            end else begin
                lit_pending = DIRECTED_ROWS[r].has_lit;
                lit_value   = DIRECTED_ROWS[r].lit;
                push_word(DIRECTED_ROWS[r].f0, DIRECTED_ROWS[r].f1);
            end
        end

        // random words, new keys every so often, one sender idle rate per phase
        for (int ph = 0; ph < 4; ph++) begin
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (n % KEY_INTERVAL == 0) random_keys();
                sender_gap(pct[ph]);
                push_word(pick_word(), pick_word());
            end
        end

        drain();
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
